[rtl/mtg_pkg.sv]
// ----------------------------------------------------------------------------
// mtg_pkg
// Shared types, constants and word functions of the MT19937 generator.
// ----------------------------------------------------------------------------
package mtg_pkg;

    localparam int WORD_W      = 32;
    localparam int STATE_DEPTH = 624;
    localparam int TWIST_OFFSET = 397;
    localparam int IDX_W       = $clog2(STATE_DEPTH);

    localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_b0df;
    localparam logic [WORD_W-1:0] HIGH_BIT     = 32'h8000_0000;
    localparam logic [WORD_W-1:0] LOW_BITS     = 32'h7fff_ffff;
    localparam logic [WORD_W-1:0] INIT_MULT    = 32'd1812433253;
    localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'd5489;
    localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c_5680;
    localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc6_0000;
    localparam logic [IDX_W-1:0]  LAST_IDX     = IDX_W'(STATE_DEPTH - 1);

    // one word shifted into the chain by the seeder
    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] word;
    } fill_t;

    // new state word from the current, next and far words
    function automatic logic [WORD_W-1:0] twist_word(
        input logic [WORD_W-1:0] cur,
        input logic [WORD_W-1:0] nxt,
        input logic [WORD_W-1:0] far
    );
        logic [WORD_W-1:0] y;
        logic [WORD_W-1:0] t;
        y = (cur & HIGH_BIT) | (nxt & LOW_BITS);
        t = far ^ (y >> 1);
        if (y[0])
        begin
            t = t ^ TWIST_MATRIX;
        end
        return t;
    endfunction

    // output tempering
    function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] y;
        y = w ^ (w >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

[rtl/mtg_cell.sv]
// ----------------------------------------------------------------------------
// mtg_cell
// One state word of the generator chain; loads the word on its d input on shift.
// ----------------------------------------------------------------------------
module mtg_cell
    import mtg_pkg::*;
(
    input  logic              clk,
    input  logic              shift_en,
    input  logic [WORD_W-1:0] d,
    output logic [WORD_W-1:0] q
);

    logic [WORD_W-1:0] word_reg;

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            word_reg <= d;
        end
    end

    assign q = word_reg;

endmodule

[rtl/mtg_seed.sv]
// ----------------------------------------------------------------------------
// mtg_seed
// Seeding sequencer: emits w[0] = seed, then w[i] = 1812433253 *
// (w[i-1] ^ (w[i-1] >> 30)) + i, each word from a multiply state then an add state.
// ----------------------------------------------------------------------------
module mtg_seed
    import mtg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WORD_W-1:0] seed,
    output fill_t             fill,
    output logic              done
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_ADD  = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [WORD_W-1:0] prev_reg, prev_next;
    logic [WORD_W-1:0] prod_reg, prod_next;
    logic [WORD_W-1:0] mix;
    logic [WORD_W-1:0] sum;

    assign mix = prev_reg ^ (prev_reg >> 30);
    assign sum = prod_reg + {{(WORD_W-IDX_W){1'b0}}, idx_reg};

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        prev_next  = prev_reg;
        prod_next  = prod_reg;
        fill.valid = 1'b0;
        fill.word  = sum;
        done       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    fill.valid = 1'b1;
                    fill.word  = seed;
                    prev_next  = seed;
                    idx_next   = IDX_W'(1);
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                prod_next  = 32'(INIT_MULT * mix);
                state_next = S_ADD;
            end
            S_ADD:
            begin
                fill.valid = 1'b1;
                prev_next  = sum;
                if (idx_reg == LAST_IDX)
                begin
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = S_MUL;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        prev_reg <= prev_next;
        prod_reg <= prod_next;
    end

endmodule

[rtl/mersenne_twister_generator.sv]
// ----------------------------------------------------------------------------
// mersenne_twister_generator
// MT19937 generator built as a 624-cell shift chain with an on-the-fly twist.
// ----------------------------------------------------------------------------
// Each transfer on the input stream with tdata bit 0 set yields one tempered
// 32-bit MT19937 word on the output stream; a transfer with bit 0 clear is
// taken and yields nothing. Once seeded the block returns one word per cycle
// while the output is not stalled: each draw twists the oldest word of the
// chain from chain cells 0, 1 and 397 and shifts the chain by one. The first
// draw after reset or after a write of the seed register refills the chain
// from the seed (default 5489) via the seeder's multiply and add states, then
// twists its word. The seed register is to be written only while the block is
// idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module mersenne_twister_generator
    import mtg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write: seed word
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] draw_request, [7:1] zero
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] random_word
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SEED = 2'd1;
    localparam logic [1:0] ST_GEN  = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic              needs_seeding_reg, needs_seeding_next;
    logic [WORD_W-1:0] seed_reg, seed_next;
    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] out_data_reg, out_data_next;

    logic              out_free;
    logic              accept;
    logic              draw;
    logic              produce;
    logic              seed_start;
    logic              seed_done;
    fill_t             fill;
    logic              shift_en;
    logic [WORD_W-1:0] chain_in;
    logic [WORD_W-1:0] twisted;
    logic [WORD_W-1:0] chain_q [STATE_DEPTH];

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && out_free;
    assign accept    = s_tvalid && s_tready;
    assign draw      = accept && s_tdata[0];

    // word handed out on a draw from a seeded chain, or when seeding has finished
    assign produce = (draw && !needs_seeding_reg)
                     || ((state_reg == ST_GEN) && out_free);
    assign seed_start = draw && needs_seeding_reg;

    // seeding sequencer
    mtg_seed u_seed (
        .clk   (clk),
        .rst_n (rst_n),
        .start (seed_start),
        .seed  (seed_reg),
        .fill  (fill),
        .done  (seed_done)
    );

    // twist of the oldest word
    assign twisted  = twist_word(chain_q[0], chain_q[1], chain_q[TWIST_OFFSET]);
    assign shift_en = fill.valid || produce;
    assign chain_in = fill.valid ? fill.word : twisted;

    // state chain: cell 0 is the oldest word, new words enter at the tail
    genvar k;
    generate
        for (k = 0; k < STATE_DEPTH; k++)
        begin : g_cell
            if (k == STATE_DEPTH - 1)
            begin : g_tail
                mtg_cell u_cell (
                    .clk      (clk),
                    .shift_en (shift_en),
                    .d        (chain_in),
                    .q        (chain_q[k])
                );
            end
            else
            begin : g_body
                mtg_cell u_cell (
                    .clk      (clk),
                    .shift_en (shift_en),
                    .d        (chain_q[k+1]),
                    .q        (chain_q[k])
                );
            end
        end
    endgenerate

    // control and output register
    always_comb
    begin
        state_next         = state_reg;
        needs_seeding_next = needs_seeding_reg;
        seed_next          = seed_reg;
        out_valid_next     = out_valid_reg && !m_tready;
        out_data_next      = out_data_reg;

        if (cfg_valid && cfg_ready)
        begin
            seed_next          = cfg_data;
            needs_seeding_next = 1'b1;
        end

        if (produce)
        begin
            out_valid_next = 1'b1;
            out_data_next  = temper(twisted);
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (seed_start)
                begin
                    needs_seeding_next = 1'b0;
                    state_next         = ST_SEED;
                end
            end
            ST_SEED:
            begin
                if (seed_done)
                begin
                    state_next = ST_GEN;
                end
            end
            ST_GEN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            needs_seeding_reg <= 1'b1;
            seed_reg          <= DEFAULT_SEED;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            needs_seeding_reg <= needs_seeding_next;
            seed_reg          <= seed_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    // a new word never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        produce |-> (!out_valid_reg || m_tready))
        else $error("output word overwritten");

    // a draw on an unseeded chain starts seeding
    a_seed_entry: assert property (@(posedge clk) disable iff (!rst_n)
        seed_start |=> (state_reg == ST_SEED))
        else $error("seeding did not start");

    // the seeder only finishes while the controller waits for it
    a_done_in_seed: assert property (@(posedge clk) disable iff (!rst_n)
        seed_done |-> (state_reg == ST_SEED))
        else $error("seeding finished outside seed phase");

    // chain fill and draw shifts never collide
    a_no_shift_clash: assert property (@(posedge clk) disable iff (!rst_n)
        fill.valid |-> !produce)
        else $error("seed fill and draw shift in the same cycle");
`endif

endmodule
